@@ hw/rtl/mrpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpq_pkg
// Shared types and constants for the multi-ring packet queue.
// ----------------------------------------------------------------------------
package mrpq_pkg;

  localparam int QUEUE_IDX_W  = 2;
  localparam int NUM_QUEUES   = 2 ** QUEUE_IDX_W;
  localparam int PTR_W        = 10;
  localparam int RING_SLOTS   = 2 ** PTR_W;
  localparam int HANDLE_WIDTH = 32;
  localparam int SLOT_ADDR_W  = QUEUE_IDX_W + PTR_W;
  localparam int CAP_W        = 10;
  localparam int LEN_W        = 10;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1000);
  localparam logic [PTR_W-1:0] MAX_CAP        = PTR_W'(RING_SLOTS - 1);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [QUEUE_IDX_W-1:0]  queue_index;
    logic [HANDLE_WIDTH-1:0] packet_handle;
  } item_t;

  typedef struct packed {
    logic                    pulled_valid;
    logic [HANDLE_WIDTH-1:0] pulled_handle;
    logic                    dropped;
    logic [LEN_W-1:0]        queue_length;
    logic [LEN_W-1:0]        high_water;
    logic                    overflow_seen;
  } result_t;

  // entries between head and tail on a ring of cap+1 slots
  function automatic logic [LEN_W-1:0] ring_len(input logic [PTR_W-1:0] h,
                                                input logic [PTR_W-1:0] t,
                                                input logic [PTR_W-1:0] cap);
    logic [PTR_W:0] wrapped;
    wrapped = {1'b0, cap} + (PTR_W+1)'(1) + {1'b0, t} - {1'b0, h};
    if (t >= h) begin
      return LEN_W'(t - h);
    end
    return LEN_W'(wrapped[PTR_W-1:0]);
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] i,
                                               input logic [PTR_W-1:0] cap);
    return (i >= cap) ? '0 : i + PTR_W'(1);
  endfunction

endpackage

@@ hw/rtl/multi_ring_packet_queue.sv @@
// ----------------------------------------------------------------------------
// multi_ring_packet_queue
// Four circular FIFOs of packet handles sharing one slot memory.
// ----------------------------------------------------------------------------
// A new item is not taken while a result is out: in the cycle after start is
// accepted, result_valid pulses for one cycle with the result and busy is
// high, because a pull reads the handle from the synchronous slot memory and
// the result is presented from that read register. The receiver cannot hold
// results off; each result is present for that one cycle only. A write to
// capacity empties every ring; high_water and overflow_seen keep their values.
// Slots are only read after being written, so the slot memory needs no
// clearing after reset.
module multi_ring_packet_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  mrpq_pkg::item_t        item,
  output logic                   result_valid,
  output mrpq_pkg::result_t      result,
  input  logic                   cfg_we,
  input  logic [mrpq_pkg::CAP_W-1:0] cfg_wdata
);

  logic [mrpq_pkg::CAP_W-1:0]        capacity;
  logic [mrpq_pkg::PTR_W-1:0]        head [mrpq_pkg::NUM_QUEUES];
  logic [mrpq_pkg::PTR_W-1:0]        tail [mrpq_pkg::NUM_QUEUES];
  logic [mrpq_pkg::LEN_W-1:0]        high_water;
  logic                              overflow;

  logic [mrpq_pkg::HANDLE_WIDTH-1:0] slot_mem [mrpq_pkg::NUM_QUEUES * mrpq_pkg::RING_SLOTS];
  logic [mrpq_pkg::HANDLE_WIDTH-1:0] rd_data;

  logic                              res_pv;
  logic                              res_drop;
  logic [mrpq_pkg::LEN_W-1:0]        res_len;

  logic                              accept;
  logic [mrpq_pkg::PTR_W-1:0]        cap;
  logic [mrpq_pkg::PTR_W-1:0]        h;
  logic [mrpq_pkg::PTR_W-1:0]        t;
  logic [mrpq_pkg::PTR_W-1:0]        nt;
  logic [mrpq_pkg::PTR_W-1:0]        nh;
  logic                              push_ok;
  logic                              push_drop;
  logic                              pull_ok;
  logic [mrpq_pkg::LEN_W-1:0]        len_next;
  logic [mrpq_pkg::LEN_W-1:0]        high_water_next;
  logic                              overflow_next;
  logic [mrpq_pkg::SLOT_ADDR_W-1:0]  slot_addr;

  assign accept = start && !busy;
  assign busy   = result_valid;

  always_comb begin
    cap = (capacity > mrpq_pkg::CAP_W'(mrpq_pkg::MAX_CAP)) ? mrpq_pkg::MAX_CAP
                                                           : mrpq_pkg::PTR_W'(capacity);
    h   = head[item.queue_index];
    t   = tail[item.queue_index];
    nt  = mrpq_pkg::advance(t, cap);
    nh  = mrpq_pkg::advance(h, cap);
    push_ok   = accept && (item.mode == mrpq_pkg::MODE_PUSH) && (nt != h);
    push_drop = accept && (item.mode == mrpq_pkg::MODE_PUSH) && (nt == h);
    pull_ok   = accept && (item.mode == mrpq_pkg::MODE_PULL) && (h != t);
    slot_addr = {item.queue_index, (item.mode == mrpq_pkg::MODE_PUSH) ? t : h};

    len_next = mrpq_pkg::ring_len(h, t, cap);
    if (push_ok) begin
      len_next = mrpq_pkg::ring_len(h, nt, cap);
    end else if (pull_ok) begin
      len_next = mrpq_pkg::ring_len(nh, t, cap);
    end

    high_water_next = high_water;
    if (push_ok && (len_next > high_water)) begin
      high_water_next = len_next;
    end
    overflow_next = overflow || (push_drop && (cap != '0));
  end

  // slot memory: push writes at the tail, pull reads at the head
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_mem[slot_addr] <= item.packet_handle;
    end
    if (pull_ok) begin
      rd_data <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= mrpq_pkg::CAPACITY_RESET;
      high_water   <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
      res_pv       <= 1'b0;
      for (int i = 0; i < mrpq_pkg::NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      result_valid <= accept;
      if (cfg_we) begin
        capacity <= cfg_wdata;
        for (int i = 0; i < mrpq_pkg::NUM_QUEUES; i++) begin
          head[i] <= '0;
          tail[i] <= '0;
        end
      end else if (accept) begin
        high_water <= high_water_next;
        overflow   <= overflow_next;
        res_pv     <= pull_ok;
        if (push_ok) begin
          tail[item.queue_index] <= nt;
        end
        if (pull_ok) begin
          head[item.queue_index] <= nh;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_drop <= push_drop;
      res_len  <= len_next;
    end
  end

  always_comb begin
    result.pulled_valid  = res_pv;
    result.pulled_handle = res_pv ? rd_data : '0;
    result.dropped       = res_drop;
    result.queue_length  = res_len;
    result.high_water    = high_water;
    result.overflow_seen = overflow;
  end

endmodule

@@ hw/rtl/mrpq_checker.sv @@
// ----------------------------------------------------------------------------
// mrpq_checker
// Port-level checks for the multi-ring packet queue.
// ----------------------------------------------------------------------------
module mrpq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input mrpq_pkg::result_t result
);

  // every accepted beat gives its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> result_valid)
    else $error("accepted beat produced no result");

  a_pull_not_dropped: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.pulled_valid) |-> !result.dropped)
    else $error("pull result flagged as dropped");

  a_empty_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.pulled_valid) |-> (result.pulled_handle == '0))
    else $error("handle non-zero without a pulled packet");

  // overflow is sticky
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(result.overflow_seen)) |-> result.overflow_seen)
    else $error("overflow flag cleared");

  // high water never falls
  a_high_water_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (result.high_water >= $past(result.high_water)))
    else $error("high water decreased");

endmodule

bind multi_ring_packet_queue mrpq_checker u_mrpq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

@@ dv/multi_ring_packet_queue_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_ring_packet_queue_test
// Self-checking bench for the four-ring packet handle queue. Directed beats
// cover empty pulls, full pushes, zero capacity and wrap-around. Random phases
// then run at a range of capacities and push/pull mixes. A scoreboard keeps
// its own copy of every ring and checks each result strobe in order.
// ----------------------------------------------------------------------------
module multi_ring_packet_queue_test;

  localparam int TOTAL_ITEMS = 1300;
  localparam int STALL_LIMIT = 400;

  class ring_scoreboard;
    logic [mrpq_pkg::CAP_W-1:0]        capacity;
    int                                head [mrpq_pkg::NUM_QUEUES];
    int                                tail [mrpq_pkg::NUM_QUEUES];
    logic [mrpq_pkg::HANDLE_WIDTH-1:0] slots [mrpq_pkg::NUM_QUEUES][mrpq_pkg::RING_SLOTS];
    int                                peak_len;
    logic                              overflow;
    mrpq_pkg::result_t                 awaited [$];
    int faults, results_seen, pushes, pulls, drops, hits;

    function new();
      capacity = mrpq_pkg::CAPACITY_RESET;
      foreach (head[q]) begin
        head[q] = 0;
        tail[q] = 0;
      end
      peak_len = 0;
      overflow = 1'b0;
      faults = 0;
      results_seen = 0;
      pushes = 0;
      pulls = 0;
      drops = 0;
      hits = 0;
    endfunction

    // a capacity write empties every ring, peak and overflow stay
    function void set_capacity(logic [mrpq_pkg::CAP_W-1:0] v);
      capacity = v;
      foreach (head[q]) begin
        head[q] = 0;
        tail[q] = 0;
      end
    endfunction

    function int next_slot(int i, int c);
      return (i >= c) ? 0 : i + 1;
    endfunction

    function int occupancy(int h, int t, int c);
      return (t >= h) ? t - h : c + 1 + t - h;
    endfunction

    function void note_item(mrpq_pkg::item_t it);
      mrpq_pkg::result_t want;
      int c, h, t, nt, q, len;
      c = (int'(capacity) > mrpq_pkg::RING_SLOTS - 1) ? mrpq_pkg::RING_SLOTS - 1
                                                       : int'(capacity);
      q = int'(it.queue_index);
      h = head[q];
      t = tail[q];
      want = '0;
      if (it.mode == mrpq_pkg::MODE_PUSH) begin
        pushes++;
        nt = next_slot(t, c);
        if (nt != h) begin
          slots[q][t] = it.packet_handle;
          tail[q] = nt;
          len = occupancy(h, nt, c);
          if (len > peak_len) peak_len = len;
        end else begin
          // full ring: beat is discarded, zero capacity never flags
          want.dropped = 1'b1;
          drops++;
          if (c > 0) overflow = 1'b1;
          len = occupancy(h, t, c);
        end
      end else begin
        pulls++;
        if (h != t) begin
          want.pulled_valid  = 1'b1;
          want.pulled_handle = slots[q][h];
          h = next_slot(h, c);
          head[q] = h;
          hits++;
        end
        len = occupancy(h, t, c);
      end
      want.queue_length  = mrpq_pkg::LEN_W'(len);
      want.high_water    = mrpq_pkg::LEN_W'(peak_len);
      want.overflow_seen = overflow;
      awaited.push_back(want);
    endfunction

    function void check_result(mrpq_pkg::result_t got);
      mrpq_pkg::result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got.pulled_valid !== want.pulled_valid ||
          got.pulled_handle !== want.pulled_handle ||
          got.dropped !== want.dropped ||
          got.queue_length !== want.queue_length ||
          got.high_water !== want.high_water ||
          got.overflow_seen !== want.overflow_seen) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch at result %0d", results_seen);
          $display("  expected valid=%0d handle=%h dropped=%0d len=%0d hw=%0d ovf=%0d",
                   want.pulled_valid, want.pulled_handle, want.dropped,
                   want.queue_length, want.high_water, want.overflow_seen);
          $display("  actual   valid=%0d handle=%h dropped=%0d len=%0d hw=%0d ovf=%0d",
                   got.pulled_valid, got.pulled_handle, got.dropped,
                   got.queue_length, got.high_water, got.overflow_seen);
        end
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  mrpq_pkg::item_t             item = '0;
  logic                        result_valid;
  mrpq_pkg::result_t           result;
  logic                        cfg_we = 1'b0;
  logic [mrpq_pkg::CAP_W-1:0]  cfg_wdata = '0;

  ring_scoreboard sb;
  int items_sent = 0;
  int cap_writes = 0;
  int stall_cycles = 0;

  multi_ring_packet_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) sb.check_result(result);
  end

  // no input beat accepted for too long means a hang
  always @(posedge clk) begin
    if (rst || (start && !busy)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic mrpq_pkg::item_t pack_item(logic m, int q,
                                                logic [mrpq_pkg::HANDLE_WIDTH-1:0] h);
    mrpq_pkg::item_t it;
    it.mode          = m;
    it.queue_index   = mrpq_pkg::QUEUE_IDX_W'(q);
    it.packet_handle = h;
    return it;
  endfunction

  function automatic mrpq_pkg::item_t random_item(int push_pct, int fav_q);
    logic [mrpq_pkg::HANDLE_WIDTH-1:0] h;
    int q;
    case ($urandom_range(0, 9))
      0:       h = '0;
      1:       h = '1;
      default: h = $urandom;
    endcase
    q = ($urandom_range(0, 1) == 0) ? fav_q : $urandom_range(0, mrpq_pkg::NUM_QUEUES - 1);
    return pack_item(($urandom_range(0, 99) < push_pct) ? mrpq_pkg::MODE_PUSH
                                                         : mrpq_pkg::MODE_PULL, q, h);
  endfunction

  // start stays high across back-to-back beats
  task automatic send_item(mrpq_pkg::item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic reconfigure(logic [mrpq_pkg::CAP_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(v);
    cap_writes++;
  endtask

  task automatic run_phase(logic [mrpq_pkg::CAP_W-1:0] cap, int n, int push_pct, int fav_q,
                           bit quiet, int drain_at);
    reconfigure(cap);
    for (int i = 0; i < n; i++) begin
      if (i == drain_at) drain_results();
      if (!quiet && $urandom_range(0, 99) < 35) hold_off($urandom_range(1, 4));
      send_item(random_item(push_pct, fav_q));
    end
  endtask

  initial begin
    int pct;
    logic [mrpq_pkg::CAP_W-1:0] cap_pick;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pull, extreme handles into every ring, then back out
    send_item(pack_item(mrpq_pkg::MODE_PULL, 0, '0));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 0, 32'hFFFF_FFFF));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 1, 32'h0000_0000));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 2, 32'hA5A5_A5A5));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 3, 32'h5A5A_5A5A));
    for (int q = 0; q < mrpq_pkg::NUM_QUEUES; q++) begin
      send_item(pack_item(mrpq_pkg::MODE_PULL, q, '1));
    end
    send_item(pack_item(mrpq_pkg::MODE_PULL, 3, '0));

    // zero capacity: every push drops, overflow stays clear
    reconfigure('0);
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 1, 32'h1234_5678));
    send_item(pack_item(mrpq_pkg::MODE_PULL, 1, '0));

    // tiny ring: fill past full, drain, then wrap round
    reconfigure(mrpq_pkg::CAP_W'(2));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 2, 32'h0000_0001));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 2, 32'h0000_0002));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 2, 32'h0000_0003));
    send_item(pack_item(mrpq_pkg::MODE_PULL, 2, '0));
    send_item(pack_item(mrpq_pkg::MODE_PULL, 2, '0));
    send_item(pack_item(mrpq_pkg::MODE_PULL, 2, '0));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 2, 32'hDEAD_BEEF));
    send_item(pack_item(mrpq_pkg::MODE_PUSH, 2, 32'hFFFF_0000));
    send_item(pack_item(mrpq_pkg::MODE_PULL, 2, '0));

    // largest ring, back to back with no gaps and one full drain midway
    run_phase(mrpq_pkg::MAX_CAP, 300, 85, 0, 1'b1, 150);

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2:    cap_pick = '0;
        3, 4, 5:    cap_pick = mrpq_pkg::CAP_W'($urandom_range(0, 1023));
        6, 7:       cap_pick = mrpq_pkg::MAX_CAP;
        default:    cap_pick = mrpq_pkg::CAP_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 3))
        0:       pct = 30;
        1:       pct = 50;
        2:       pct = 70;
        default: pct = 85;
      endcase
      run_phase(cap_pick, $urandom_range(40, 120), pct,
                $urandom_range(0, mrpq_pkg::NUM_QUEUES - 1),
                $urandom_range(0, 4) == 0,
                ($urandom_range(0, 2) == 0) ? $urandom_range(0, 39) : -1);
    end

    drain_results();
    $display("ran %0d beats (%0d pushes, %0d pulls) over %0d capacity writes",
             items_sent, sb.pushes, sb.pulls, cap_writes);
    $display("checked %0d results: %0d handles pulled, %0d pushes dropped, %0d faults",
             sb.results_seen, sb.hits, sb.drops, sb.faults);
    if (sb.faults == 0 && sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ multi_ring_packet_queue.f @@
hw/rtl/mrpq_pkg.sv
hw/rtl/multi_ring_packet_queue.sv
hw/rtl/mrpq_checker.sv
dv/multi_ring_packet_queue_test.sv
